// ===== rtl/core/mrwt_pkg.sv =====
package mrwt_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int FIELD_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECOMP,
		ST_REDUCE,
		ST_POW_SQ,
		ST_POW_MUL,
		ST_CHECK,
		ST_LOOP_SQ,
		ST_DONE
	} mrwt_state_t;

endpackage

// ===== rtl/core/miller_rabin_witness_test.sv =====
// A candidate below three goes from idle straight to the result beat and is rejected.
// Throughput: one test at a time; busy stays high through the result beat.
// Every modular product goes through one shared shift-add multiplier that doubles for each
// multiplier bit and adds the multiplicand for each set bit. The result beat cannot be held off.
// Reset is asynchronous and active low; it returns the block to idle at once.
module miller_rabin_witness_test #(
	parameter int WIDTH = mrwt_pkg::WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [mrwt_pkg::FIELD_W-1:0] candidate,
	input  logic [mrwt_pkg::FIELD_W-1:0] witness_base,
	output logic                         done,
	output logic                         probably_prime
);
	import mrwt_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);
	localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

	mrwt_state_t state_q, state_d;

	logic [WIDTH-1:0] n_in, b_in;
	logic [WIDTH-1:0] n_q, nm1_q, b_q, e_q, a_q;
	logic [WIDTH-1:0] mx_q, my_q, mp_q;
	logic [CNT_W-1:0] mcnt_q, ecnt_q, s_q, rem_q;
	logic             phase_q, verdict_q;

	logic [WIDTH-1:0] n_d, nm1_d, b_d, e_d, a_d, mx_d, my_d, mp_d;
	logic [CNT_W-1:0] mcnt_d, ecnt_d, s_d, rem_d;
	logic             phase_d, verdict_d;

	logic [WIDTH-1:0] add_op, mod_res;
	logic [WIDTH:0]   sum, diff;
	logic             mul_state, mul_fin;

	assign n_in = WIDTH'(candidate);
	assign b_in = WIDTH'(witness_base);

	// One modular addition per cycle: doubling in the first phase, adding x in the second.
	assign add_op  = phase_q ? mx_q : mp_q;
	assign sum     = {1'b0, mp_q} + {1'b0, add_op};
	assign diff    = sum - {1'b0, n_q};
	assign mod_res = (sum >= {1'b0, n_q}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];

	assign mul_state = (state_q == ST_REDUCE) || (state_q == ST_POW_SQ) ||
		(state_q == ST_POW_MUL) || (state_q == ST_LOOP_SQ);
	assign mul_fin = mul_state && (mcnt_q == '0) && (phase_q || !my_q[WIDTH-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= 1'b0;
			verdict_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			verdict_q <= verdict_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q    <= n_d;
		nm1_q  <= nm1_d;
		b_q    <= b_d;
		e_q    <= e_d;
		a_q    <= a_d;
		mx_q   <= mx_d;
		my_q   <= my_d;
		mp_q   <= mp_d;
		mcnt_q <= mcnt_d;
		ecnt_q <= ecnt_d;
		s_q    <= s_d;
		rem_q  <= rem_d;
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		verdict_d = verdict_q;
		n_d       = n_q;
		nm1_d     = nm1_q;
		b_d       = b_q;
		e_d       = e_q;
		a_d       = a_q;
		mx_d      = mx_q;
		my_d      = my_q;
		mp_d      = mp_q;
		mcnt_d    = mcnt_q;
		ecnt_d    = ecnt_q;
		s_d       = s_q;
		rem_d     = rem_q;

		// Multiplier step, shared by every state that forms a product.
		if (mul_state) begin
			mp_d = mod_res;
			if (!phase_q && my_q[WIDTH-1]) begin
				phase_d = 1'b1;
			end else begin
				phase_d = 1'b0;
				my_d    = my_q << 1;
				mcnt_d  = mcnt_q - CNT_W'(1);
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					n_d     = n_in;
					nm1_d   = n_in - ONE;
					e_d     = n_in - ONE;
					s_d     = '0;
					mx_d    = ONE;
					my_d    = b_in;
					mp_d    = '0;
					mcnt_d  = LAST_BIT;
					phase_d = 1'b0;
					if (n_in < WIDTH'(3)) begin
						verdict_d = 1'b0;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_DECOMP;
					end
				end
			end
			ST_DECOMP: begin
				if (!e_q[0]) begin
					e_d = e_q >> 1;
					s_d = s_q + CNT_W'(1);
				end else begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mul_fin) begin
					b_d     = mod_res;
					a_d     = ONE;
					ecnt_d  = LAST_BIT;
					mx_d    = ONE;
					my_d    = ONE;
					mp_d    = '0;
					mcnt_d  = LAST_BIT;
					state_d = ST_POW_SQ;
				end
			end
			ST_POW_SQ, ST_POW_MUL: begin
				if (mul_fin) begin
					a_d    = mod_res;
					mp_d   = '0;
					mcnt_d = LAST_BIT;
					if (state_q == ST_POW_SQ && e_q[WIDTH-1]) begin
						mx_d    = mod_res;
						my_d    = b_q;
						state_d = ST_POW_MUL;
					end else if (ecnt_q == '0) begin
						state_d = ST_CHECK;
					end else begin
						ecnt_d  = ecnt_q - CNT_W'(1);
						e_d     = e_q << 1;
						mx_d    = mod_res;
						my_d    = mod_res;
						state_d = ST_POW_SQ;
					end
				end
			end
			ST_CHECK: begin
				mx_d    = a_q;
				my_d    = a_q;
				mp_d    = '0;
				mcnt_d  = LAST_BIT;
				rem_d   = s_q - CNT_W'(1);
				if (a_q == ONE || a_q == nm1_q) begin
					verdict_d = 1'b1;
					state_d   = ST_DONE;
				end else if (s_q <= CNT_W'(1)) begin
					verdict_d = 1'b0;
					state_d   = ST_DONE;
				end else begin
					state_d = ST_LOOP_SQ;
				end
			end
			ST_LOOP_SQ: begin
				if (mul_fin) begin
					mx_d   = mod_res;
					my_d   = mod_res;
					mp_d   = '0;
					mcnt_d = LAST_BIT;
					if (mod_res == ONE) begin
						verdict_d = 1'b0;
						state_d   = ST_DONE;
					end else if (mod_res == nm1_q) begin
						verdict_d = 1'b1;
						state_d   = ST_DONE;
					end else if (rem_q == CNT_W'(1)) begin
						verdict_d = 1'b0;
						state_d   = ST_DONE;
					end else begin
						rem_d = rem_q - CNT_W'(1);
					end
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = (state_q == ST_DONE);
	assign probably_prime = verdict_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted test");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat lasted more than one cycle");

	a_small_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && n_in < WIDTH'(3) |=> done && !probably_prime)
		else $error("small candidate not rejected at once");

	a_add_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> mul_state && my_q[WIDTH-1])
		else $error("add phase without a set multiplier bit");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POW_SQ || state_q == ST_LOOP_SQ) |-> mp_q < n_q && mx_q < n_q)
		else $error("multiplier operand not reduced");

endmodule
